>>> hw/rtl/rvs_pkg.sv
// Shared constants, codes and types for the RV32I subset core.
`default_nettype none

package rvs_pkg;

    // Machine sizes.
    localparam int XLEN       = 32;
    localparam int NUM_REGS   = 32;
    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int DMEM_WORDS = 4096;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);
    localparam int MIDX_W     = 12;

    // Major opcodes.
    localparam logic [6:0] OPC_R    = 7'h33;
    localparam logic [6:0] OPC_I    = 7'h13;
    localparam logic [6:0] OPC_LW   = 7'h03;
    localparam logic [6:0] OPC_S    = 7'h23;
    localparam logic [6:0] OPC_B    = 7'h63;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [6:0] OPC_END  = 7'h00;

    // Function codes.
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SRA  = 3'b101;
    localparam logic [2:0] F3_AND  = 3'b111;
    localparam logic [2:0] F3_WORD = 3'b010;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_JALR = 3'b000;

    // Completion status of one instruction.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_OOB     = 2'd2,
        ST_TERM    = 2'd3
    } t_status;

    // Result of the execute logic for one instruction.
    typedef struct packed {
        logic [XLEN-1:0]   npc;
        logic              wr;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   val;
        logic              mw;
        logic [XLEN-1:0]   mem_addr;
        logic [MIDX_W-1:0] midx;
        logic [XLEN-1:0]   mval;
        t_status           status;
        logic              is_load;
        logic [XLEN-1:0]   rtype;
    } t_exec_res;

endpackage

`default_nettype wire

>>> hw/rtl/rvs_regfile.sv
// Register file with two registered read ports, one write port and write bypass.
`default_nettype none

module rvs_regfile
    import rvs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_re,
    input  wire logic [REG_AW-1:0] i_ra,
    input  wire logic [REG_AW-1:0] i_rb,
    input  wire logic              i_we,
    input  wire logic [REG_AW-1:0] i_waddr,
    input  wire logic [XLEN-1:0]   i_wdata,
    output logic      [XLEN-1:0]   o_a,
    output logic      [XLEN-1:0]   o_b
);

    logic [XLEN-1:0]     r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [XLEN-1:0]     r_a;
    logic [XLEN-1:0]     r_b;
    logic                wr_ok;

    // Register zero is never written.
    assign wr_ok = i_we && (i_waddr != '0);

    // Entry valid bits; an entry that was never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered reads; a write in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (wr_ok && (i_waddr == i_ra)) begin
                r_a <= i_wdata;
            end else begin
                r_a <= r_vld[i_ra] ? r_mem[i_ra] : '0;
            end
            if (wr_ok && (i_waddr == i_rb)) begin
                r_b <= i_wdata;
            end else begin
                r_b <= r_vld[i_rb] ? r_mem[i_rb] : '0;
            end
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

`default_nettype wire

>>> hw/rtl/rvs_dmem.sv
// Word-addressed data memory with a registered read and a clearing pass after reset.
`default_nettype none

module rvs_dmem
    import rvs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [DMEM_AW-1:0] i_addr,
    input  wire logic               i_we,
    input  wire logic [XLEN-1:0]    i_wdata,
    input  wire logic               i_re,
    output logic      [XLEN-1:0]    o_rdata,
    output logic                    o_clr_done
);

    logic [XLEN-1:0]    r_mem [DMEM_WORDS];
    logic [XLEN-1:0]    r_rdata;
    logic [DMEM_AW-1:0] r_clr_idx;
    logic               r_clr_done;

    // Clearing sweep, one word per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_idx <= r_clr_idx + DMEM_AW'(1);
            if (r_clr_idx == DMEM_AW'(DMEM_WORDS - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_done = r_clr_done;

endmodule

`default_nettype wire

>>> hw/rtl/rvs_exec.sv
// Decode and execute logic for one instruction word.
`default_nettype none

module rvs_exec
    import rvs_pkg::*;
(
    input  wire logic [XLEN-1:0] i_ins,
    input  wire logic [XLEN-1:0] i_a,
    input  wire logic [XLEN-1:0] i_b,
    input  wire logic [XLEN-1:0] i_pc,
    input  wire logic [XLEN-1:0] i_cnt,
    output t_exec_res            o_res
);

    logic [6:0]        opc;
    logic [REG_AW-1:0] rd;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   pc4;
    logic [XLEN-1:0]   addr;
    logic [XLEN-1:0]   sum_ai;
    logic              in_range;
    logic              wr;
    logic [XLEN-1:0]   val;

    // Field and immediate extraction.
    assign opc   = i_ins[6:0];
    assign rd    = i_ins[11:7];
    assign f3    = i_ins[14:12];
    assign f7    = i_ins[31:25];
    assign imm_i = {{20{i_ins[31]}}, i_ins[31:20]};
    assign imm_s = {{20{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign imm_b = {{19{i_ins[31]}}, i_ins[31], i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign pc4   = i_pc + XLEN'(4);

    // Shared adders for immediates and memory addresses.
    assign sum_ai   = i_a + imm_i;
    assign addr     = i_a + ((opc == OPC_S) ? imm_s : imm_i);
    assign in_range = addr < XLEN'(DMEM_WORDS);

    // Main decoder.
    always_comb begin
        o_res          = '0;
        o_res.npc      = pc4;
        o_res.status   = ST_OK;
        o_res.rtype    = i_cnt;
        o_res.mem_addr = addr;
        wr             = 1'b0;
        val            = '0;
        unique case (opc)
            OPC_R: begin
                o_res.rtype = i_cnt + XLEN'(1);
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    val = i_a + i_b;
                    wr  = 1'b1;
                end else if (f3 == F3_ADD && f7 == F7_ALT) begin
                    val = i_a - i_b;
                    wr  = 1'b1;
                end else if (f3 == F3_XOR && f7 == F7_BASE) begin
                    val = i_a ^ i_b;
                    wr  = 1'b1;
                end else if (f3 == F3_SRA && f7 == F7_ALT) begin
                    val = XLEN'($signed(i_a) >>> i_b[4:0]);
                    wr  = 1'b1;
                end else begin
                    o_res.status = ST_ILLEGAL;
                end
            end
            OPC_I: begin
                if (f3 == F3_ADD) begin
                    val = sum_ai;
                    wr  = 1'b1;
                end else if (f3 == F3_AND) begin
                    val = i_a & imm_i;
                    wr  = 1'b1;
                end else begin
                    o_res.status = ST_ILLEGAL;
                end
            end
            OPC_LW: begin
                if (f3 != F3_WORD) begin
                    o_res.status = ST_ILLEGAL;
                end else begin
                    o_res.midx = addr[MIDX_W-1:0];
                    if (!in_range) begin
                        o_res.status = ST_OOB;
                    end else begin
                        o_res.is_load = 1'b1;
                    end
                end
            end
            OPC_S: begin
                if (f3 != F3_WORD) begin
                    o_res.status = ST_ILLEGAL;
                end else begin
                    o_res.midx = addr[MIDX_W-1:0];
                    if (!in_range) begin
                        o_res.status = ST_OOB;
                    end else begin
                        o_res.mw   = 1'b1;
                        o_res.mval = i_b;
                    end
                end
            end
            OPC_B: begin
                if (f3 != F3_BLT) begin
                    o_res.status = ST_ILLEGAL;
                end else if ($signed(i_a) < $signed(i_b)) begin
                    o_res.npc = i_pc + imm_b;
                end
            end
            OPC_JALR: begin
                if (f3 != F3_JALR) begin
                    o_res.status = ST_ILLEGAL;
                end else begin
                    val       = pc4;
                    wr        = 1'b1;
                    o_res.npc = {sum_ai[XLEN-1:1], 1'b0};
                end
            end
            OPC_END: begin
                o_res.status = ST_TERM;
            end
            default: begin
                o_res.status = ST_ILLEGAL;
            end
        endcase
        // Writes to register zero are dropped and reported as no write.
        if (wr && rd != '0) begin
            o_res.wr  = 1'b1;
            o_res.rd  = rd;
            o_res.val = val;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rv32i_subset_core_step.sv
// Top level of the RV32I subset core: operand read, execute, load and result stages.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_instruction
//  result    out        o_valid / i_ready   o_next_pc .. o_rtype_count
//
// An instruction reads its operands at the accepting edge and executes in the next
// cycle; its result then goes to the result register. A new instruction is taken
// every cycle unless a load or a full result register holds the flow. A legal in-range
// LW reads the data memory in the load stage, and the next instruction is held until
// its data is written back. After reset the data memory is cleared word by word with
// o_ready low. A full result register not taken stalls the execute and load stages.
`default_nettype none

module rv32i_subset_core_step
    import rvs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [XLEN-1:0]   i_instruction,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [XLEN-1:0]   o_next_pc,
    output logic                   o_reg_write,
    output logic      [REG_AW-1:0] o_dest_reg,
    output logic      [XLEN-1:0]   o_write_value,
    output logic                   o_mem_write,
    output logic      [MIDX_W-1:0] o_mem_index,
    output logic      [XLEN-1:0]   o_mem_value,
    output logic      [1:0]        o_status,
    output logic      [XLEN-1:0]   o_rtype_count
);

    // Architectural state and pipeline registers.
    logic [XLEN-1:0]   r_pc;
    logic [XLEN-1:0]   r_cnt;
    logic              r_ev;
    logic [XLEN-1:0]   r_ins;
    logic              r_lv;
    logic [REG_AW-1:0] r_l_rd;
    logic [MIDX_W-1:0] r_l_idx;

    // Result register.
    logic              r_ov;
    logic [XLEN-1:0]   r_o_npc;
    logic              r_o_wr;
    logic [REG_AW-1:0] r_o_rd;
    logic [XLEN-1:0]   r_o_val;
    logic              r_o_mw;
    logic [MIDX_W-1:0] r_o_midx;
    logic [XLEN-1:0]   r_o_mval;
    t_status           r_o_status;
    logic [XLEN-1:0]   r_o_cnt;

    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    logic [XLEN-1:0]   ld_data;
    logic              clr_done;
    t_exec_res         ex;
    logic              acc;
    logic              out_free;
    logic              e_fin;
    logic              e_to_l;
    logic              l_fin;
    logic              l_wr;
    logic              wb_en;
    logic [REG_AW-1:0] wb_addr;
    logic [XLEN-1:0]   wb_data;

    // Stage handshakes.
    assign out_free = !r_ov || i_ready;
    assign e_to_l   = r_ev && ex.is_load;
    assign e_fin    = r_ev && !ex.is_load && out_free;
    assign l_fin    = r_lv && out_free;
    assign o_ready  = clr_done && !e_to_l && (!r_ev || out_free) && (!r_lv || out_free);
    assign acc      = i_valid && o_ready;

    // Register writeback from execute or from the load stage.
    assign l_wr    = r_l_rd != '0;
    assign wb_en   = (e_fin && ex.wr) || (l_fin && l_wr);
    assign wb_addr = l_fin ? r_l_rd : ex.rd;
    assign wb_data = l_fin ? ld_data : ex.val;

    rvs_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (acc),
        .i_ra    (i_instruction[19:15]),
        .i_rb    (i_instruction[24:20]),
        .i_we    (wb_en),
        .i_waddr (wb_addr),
        .i_wdata (wb_data),
        .o_a     (op_a),
        .o_b     (op_b)
    );

    rvs_exec u_exec (
        .i_ins (r_ins),
        .i_a   (op_a),
        .i_b   (op_b),
        .i_pc  (r_pc),
        .i_cnt (r_cnt),
        .o_res (ex)
    );

    rvs_dmem u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (ex.mem_addr[DMEM_AW-1:0]),
        .i_we       (e_fin && ex.mw),
        .i_wdata    (ex.mval),
        .i_re       (e_to_l),
        .o_rdata    (ld_data),
        .o_clr_done (clr_done)
    );

    // Control state: stage valids, pc and R-type count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev  <= 1'b0;
            r_lv  <= 1'b0;
            r_ov  <= 1'b0;
            r_pc  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                r_ev <= 1'b1;
            end else if (e_fin || e_to_l) begin
                r_ev <= 1'b0;
            end
            if (e_to_l) begin
                r_lv <= 1'b1;
            end else if (l_fin) begin
                r_lv <= 1'b0;
            end
            if (e_fin || l_fin) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (e_fin || e_to_l) begin
                r_pc <= ex.npc;
            end
            if (e_fin) begin
                r_cnt <= ex.rtype;
            end
        end
    end

    // Instruction and load-stage payload.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ins <= i_instruction;
        end
        if (e_to_l) begin
            r_l_rd  <= r_ins[11:7];
            r_l_idx <= ex.midx;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (l_fin) begin
            r_o_npc    <= r_pc;
            r_o_wr     <= l_wr;
            r_o_rd     <= r_l_rd;
            r_o_val    <= l_wr ? ld_data : '0;
            r_o_mw     <= 1'b0;
            r_o_midx   <= r_l_idx;
            r_o_mval   <= '0;
            r_o_status <= ST_OK;
            r_o_cnt    <= r_cnt;
        end else if (e_fin) begin
            r_o_npc    <= ex.npc;
            r_o_wr     <= ex.wr;
            r_o_rd     <= ex.rd;
            r_o_val    <= ex.val;
            r_o_mw     <= ex.mw;
            r_o_midx   <= ex.midx;
            r_o_mval   <= ex.mval;
            r_o_status <= ex.status;
            r_o_cnt    <= ex.rtype;
        end
    end

    assign o_valid       = r_ov;
    assign o_next_pc     = r_o_npc;
    assign o_reg_write   = r_o_wr;
    assign o_dest_reg    = r_o_rd;
    assign o_write_value = r_o_val;
    assign o_mem_write   = r_o_mw;
    assign o_mem_index   = r_o_midx;
    assign o_mem_value   = r_o_mval;
    assign o_status      = r_o_status;
    assign o_rtype_count = r_o_cnt;

`ifndef SYNTHESIS
    // The execute and load stages never hold a transaction at the same time.
    a_stage_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ev && r_lv))
        else $error("execute and load stages both occupied");

    // A load leaving execute occupies the load stage alone in the next cycle.
    a_load_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_to_l |=> (r_lv && !r_ev))
        else $error("load did not move cleanly to the load stage");

    // No transaction is accepted while the data memory is being cleared.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_done |-> !o_ready)
        else $error("input accepted during memory clear");

    // A completing stage always finds room in the result register.
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_fin || l_fin) |-> (!r_ov || i_ready))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

>>> tb/tb_rv32i_subset_core_step.sv
// Self-checking testbench for the RV32I subset core step with an in-order result scoreboard.
`timescale 1ns / 100ps

import rvs_pkg::*;

// One result transaction of the core, one field per output port.
typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              reg_write;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   write_value;
    logic              mem_write;
    logic [MIDX_W-1:0] mem_index;
    logic [XLEN-1:0]   mem_value;
    t_status           status;
    logic [XLEN-1:0]   rtype_count;
} t_step_result;

// Architectural shadow of the core plus the queue of results still owed by the block.
class core_step_scoreboard;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] regs [NUM_REGS];
    logic [XLEN-1:0] dmem [DMEM_WORDS];
    logic [XLEN-1:0] rcount;
    t_step_result    pending_steps[$];
    int              failures;

    function new();
        pc = '0;
        rcount = '0;
        failures = 0;
        foreach (regs[i]) regs[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
    endfunction

    // Executes one accepted instruction on the shadow state and queues its result.
    function void note_instruction(logic [XLEN-1:0] word);
        t_step_result    r;
        logic [6:0]      opc;
        logic [6:0]      f7;
        logic [2:0]      f3;
        logic [4:0]      rd;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] imm_i;
        logic [XLEN-1:0] imm_s;
        logic [XLEN-1:0] imm_b;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] val;
        logic            wr;
        logic            oob;

        opc   = word[6:0];
        rd    = word[11:7];
        f3    = word[14:12];
        f7    = word[31:25];
        a     = regs[word[19:15]];
        b     = regs[word[24:20]];
        imm_i = {{20{word[31]}}, word[31:20]};
        imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
        imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
        r = '0;
        r.next_pc = pc + 4;
        r.status = ST_OK;
        wr = 1'b0;
        val = '0;

        case (opc)
            OPC_R: begin
                // Every R-type word counts, legal or not.
                rcount = rcount + 1;
                wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    val = a + b;
                end else if (f3 == F3_ADD && f7 == F7_ALT) begin
                    val = a - b;
                end else if (f3 == F3_XOR && f7 == F7_BASE) begin
                    val = a ^ b;
                end else if (f3 == F3_SRA && f7 == F7_ALT) begin
                    val = $signed(a) >>> b[4:0];
                end else begin
                    wr = 1'b0;
                    r.status = ST_ILLEGAL;
                end
            end
            OPC_I: begin
                wr = 1'b1;
                if (f3 == F3_ADD) begin
                    val = a + imm_i;
                end else if (f3 == F3_AND) begin
                    val = a & imm_i;
                end else begin
                    wr = 1'b0;
                    r.status = ST_ILLEGAL;
                end
            end
            OPC_LW: begin
                if (f3 != F3_WORD) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    addr = a + imm_i;
                    oob = addr[XLEN-1] || (addr >= DMEM_WORDS);
                    r.mem_index = addr[MIDX_W-1:0];
                    if (oob) begin
                        r.status = ST_OOB;
                    end else begin
                        val = dmem[addr[DMEM_AW-1:0]];
                        wr = 1'b1;
                    end
                end
            end
            OPC_S: begin
                if (f3 != F3_WORD) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    addr = a + imm_s;
                    oob = addr[XLEN-1] || (addr >= DMEM_WORDS);
                    r.mem_index = addr[MIDX_W-1:0];
                    if (oob) begin
                        r.status = ST_OOB;
                    end else begin
                        dmem[addr[DMEM_AW-1:0]] = b;
                        r.mem_write = 1'b1;
                        r.mem_value = b;
                    end
                end
            end
            OPC_B: begin
                if (f3 != F3_BLT) begin
                    r.status = ST_ILLEGAL;
                end else if ($signed(a) < $signed(b)) begin
                    r.next_pc = pc + imm_b;
                end
            end
            OPC_JALR: begin
                if (f3 != F3_JALR) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    val = pc + 4;
                    wr = 1'b1;
                    r.next_pc = (a + imm_i) & ~32'd1;
                end
            end
            OPC_END: begin
                r.status = ST_TERM;
            end
            default: begin
                r.status = ST_ILLEGAL;
            end
        endcase

        // Register x0 is never written and then reports an empty write.
        if (wr && rd != 0) begin
            regs[rd] = val;
            r.reg_write = 1'b1;
            r.dest_reg = rd;
            r.write_value = val;
        end
        pc = r.next_pc;
        r.rtype_count = rcount;
        pending_steps.push_back(r);
    endfunction

    function void show_step(string tag, t_step_result s);
        $display("  %s npc=%h wr=%b rd=%0d val=%h mw=%b idx=%h mval=%h st=%0d rt=%0d",
                 tag, s.next_pc, s.reg_write, s.dest_reg, s.write_value, s.mem_write,
                 s.mem_index, s.mem_value, s.status, s.rtype_count);
    endfunction

    // Compares one accepted result transaction with the oldest pending one.
    function void check_result(t_step_result got);
        t_step_result want;

        if (pending_steps.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("Result transaction with nothing pending:");
                show_step("got ", got);
            end
            return;
        end
        want = pending_steps.pop_front();
        if (got.next_pc !== want.next_pc || got.reg_write !== want.reg_write ||
            got.dest_reg !== want.dest_reg || got.write_value !== want.write_value ||
            got.mem_write !== want.mem_write || got.mem_index !== want.mem_index ||
            got.mem_value !== want.mem_value || got.status !== want.status ||
            got.rtype_count !== want.rtype_count) begin
            failures++;
            if (failures <= 10) begin
                $display("Result mismatch %0d:", failures);
                show_step("want", want);
                show_step("got ", got);
            end
        end
    endfunction
endclass

module tb_rv32i_subset_core_step;
    import rvs_pkg::*;

    localparam int RANDOM_ITEMS = 425;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 300;
    localparam int DRAIN_CYCLES = 20;

    // Function code that no supported instruction uses.
    localparam logic [2:0] F3_BAD = 3'b001;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [XLEN-1:0]   i_instruction = '0;
    logic              i_ready = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [XLEN-1:0]   o_next_pc;
    logic              o_reg_write;
    logic [REG_AW-1:0] o_dest_reg;
    logic [XLEN-1:0]   o_write_value;
    logic              o_mem_write;
    logic [MIDX_W-1:0] o_mem_index;
    logic [XLEN-1:0]   o_mem_value;
    logic [1:0]        o_status;
    logic [XLEN-1:0]   o_rtype_count;

    core_step_scoreboard step_board;
    int                  results_seen = 0;
    logic [XLEN-1:0]     directed_words[$];

    rv32i_subset_core_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_instruction (i_instruction),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_next_pc     (o_next_pc),
        .o_reg_write   (o_reg_write),
        .o_dest_reg    (o_dest_reg),
        .o_write_value (o_write_value),
        .o_mem_write   (o_mem_write),
        .o_mem_index   (o_mem_index),
        .o_mem_value   (o_mem_value),
        .o_status      (o_status),
        .o_rtype_count (o_rtype_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Instruction encoders.
    function automatic logic [XLEN-1:0] enc_r(logic [6:0] f7, logic [2:0] f3,
                                              logic [4:0] rd, logic [4:0] rs1,
                                              logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_R};
    endfunction

    function automatic logic [XLEN-1:0] enc_i(logic [6:0] opc, logic [2:0] f3,
                                              logic [4:0] rd, logic [4:0] rs1,
                                              logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [XLEN-1:0] enc_s(logic [2:0] f3, logic [4:0] rs1,
                                              logic [4:0] rs2, logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_S};
    endfunction

    function automatic logic [XLEN-1:0] enc_b(logic [2:0] f3, logic [4:0] rs1,
                                              logic [4:0] rs2, logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_B};
    endfunction

    // Chooses a base register and offset that reach a word index inside the data memory,
    // mostly in a small window so that loads find earlier stores.
    function automatic void pick_word_address(output logic [4:0] base,
                                              output logic [11:0] offset);
        int unsigned target;
        logic [4:0]  cand;
        longint      delta;
        logic        found;

        if ($urandom_range(0, 3) == 0) target = $urandom_range(0, DMEM_WORDS - 1);
        else target = $urandom_range(0, 63);
        found = 1'b0;
        base = '0;
        offset = target[11:0] & 12'h7FF;
        repeat (4) begin
            cand = 5'($urandom_range(1, NUM_REGS - 1));
            delta = longint'(target) - longint'($signed(step_board.regs[cand]));
            if (!found && delta >= -2048 && delta <= 2047) begin
                base = cand;
                offset = delta[11:0];
                found = 1'b1;
            end
        end
    endfunction

    // Random instruction mix: mostly legal work with random operands, some noise.
    function automatic logic [XLEN-1:0] random_instruction();
        logic [6:0]  opcodes [6];
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  base;
        logic [11:0] offset;
        logic [6:0]  f7;
        int unsigned pick;

        opcodes = '{OPC_R, OPC_I, OPC_LW, OPC_S, OPC_B, OPC_JALR};
        rd = 5'($urandom);
        rs1 = 5'($urandom);
        rs2 = 5'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8) return enc_r(F7_BASE, F3_ADD, rd, rs1, rs2);
        if (pick < 14) return enc_r(F7_ALT, F3_ADD, rd, rs1, rs2);
        if (pick < 20) return enc_r(F7_BASE, F3_XOR, rd, rs1, rs2);
        if (pick < 26) return enc_r(F7_ALT, F3_SRA, rd, rs1, rs2);
        // Doubling a register walks its bits toward the top.
        if (pick < 32) return enc_r(F7_BASE, F3_ADD, rd | 5'd1, rd | 5'd1, rd | 5'd1);
        if (pick < 44) return enc_i(OPC_I, F3_ADD, rd, rs1, 12'($urandom));
        if (pick < 50) return enc_i(OPC_I, F3_AND, rd, rs1, 12'($urandom));
        if (pick < 70) begin
            pick_word_address(base, offset);
            if (pick < 60) return enc_i(OPC_LW, F3_WORD, rd, base, offset);
            return enc_s(F3_WORD, base, rs2, offset);
        end
        if (pick < 72) return enc_i(OPC_LW, F3_WORD, rd, rs1, 12'($urandom));
        if (pick < 74) return enc_s(F3_WORD, rs1, rs2, 12'($urandom));
        if (pick < 80) return enc_b(F3_BLT, rs1, rs2, {12'($urandom), 1'b0});
        if (pick < 85) return enc_i(OPC_JALR, F3_JALR, rd, rs1, 12'($urandom));
        if (pick < 92) begin
            case ($urandom_range(0, 2))
                0: f7 = F7_BASE;
                1: f7 = F7_ALT;
                default: f7 = 7'($urandom);
            endcase
            return {f7, rs2, rs1, 3'($urandom), rd, opcodes[$urandom_range(0, 5)]};
        end
        if (pick < 97) return $urandom;
        return {25'($urandom), OPC_END};
    endfunction

    // Offers one instruction and waits for its transaction; returns at a falling edge.
    task automatic send_instruction(input logic [XLEN-1:0] word);
        i_valid <= 1'b1;
        i_instruction <= word;
        do @(posedge i_clk); while (!o_ready);
        step_board.note_instruction(word);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_step_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.next_pc = o_next_pc;
            got.reg_write = o_reg_write;
            got.dest_reg = o_dest_reg;
            got.write_value = o_write_value;
            got.mem_write = o_mem_write;
            got.mem_index = o_mem_index;
            got.mem_value = o_mem_value;
            got.status = t_status'(o_status);
            got.rtype_count = o_rtype_count;
            step_board.check_result(got);
            results_seen++;
        end
    end

    // Receiver: stretches of full, frequent, rare and alternating readiness, plus one
    // long hold-off that backs the core up into its input.
    initial begin
        int unsigned mode;
        int unsigned span;
        logic        rdy;
        logic        holdoff_done;

        holdoff_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 48);
            repeat (span) begin
                @(negedge i_clk);
                if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                    holdoff_done = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLDOFF_LEN) @(negedge i_clk);
                end
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ~i_ready;
                endcase
                i_ready <= rdy;
            end
        end
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout with %0d results pending", step_board.pending_steps.size());
        $display("[rv32i_subset_core_step] ERROR");
        $finish;
    end

    // Stimulus and final verdict.
    initial begin
        int unsigned total;
        int unsigned sent;
        int unsigned burst;
        logic [XLEN-1:0] word;

        step_board = new();

        // Directed opening: field extremes, every operation and the corner cases.
        directed_words = '{
            enc_i(OPC_I, F3_ADD, 5'd1, 5'd0, 12'hFFF),      // x1 = -1
            enc_i(OPC_I, F3_ADD, 5'd2, 5'd0, 12'h7FF),      // x2 = 2047
            enc_i(OPC_I, F3_ADD, 5'd3, 5'd0, 12'h800),      // x3 = -2048
            enc_r(F7_BASE, F3_ADD, 5'd4, 5'd3, 5'd3),
            enc_r(F7_ALT, F3_ADD, 5'd5, 5'd0, 5'd1),
            enc_r(F7_BASE, F3_XOR, 5'd7, 5'd1, 5'd2),
            enc_r(F7_ALT, F3_SRA, 5'd6, 5'd3, 5'd2),        // shift amount masked to 31
            enc_r(F7_ALT, F3_SRA, 5'd8, 5'd1, 5'd0),        // shift by zero
            enc_r(F7_BASE, F3_ADD, 5'd0, 5'd1, 5'd2),       // write to x0 is dropped
            enc_i(OPC_I, F3_AND, 5'd9, 5'd1, 12'h800),
            enc_i(OPC_LW, F3_WORD, 5'd14, 5'd0, 12'h000),   // never-written word reads zero
            enc_s(F3_WORD, 5'd0, 5'd2, 12'h7FF),
            enc_i(OPC_LW, F3_WORD, 5'd10, 5'd0, 12'h7FF),
            enc_i(OPC_I, F3_ADD, 5'd11, 5'd2, 12'h7FF),     // x11 = 4094
            enc_s(F3_WORD, 5'd11, 5'd1, 12'h001),           // last word of memory
            enc_i(OPC_LW, F3_WORD, 5'd12, 5'd11, 12'h001),
            enc_i(OPC_LW, F3_WORD, 5'd13, 5'd11, 12'h002),  // one past the end
            enc_s(F3_WORD, 5'd0, 5'd1, 12'hFFF),            // negative word address
            enc_b(F3_BLT, 5'd3, 5'd2, 13'h1000),            // taken, most negative offset
            enc_b(F3_BLT, 5'd2, 5'd3, 13'h0FFE),            // not taken
            enc_i(OPC_JALR, F3_JALR, 5'd15, 5'd2, 12'h000), // odd target, bit 0 cleared
            enc_r(7'h01, F3_ADD, 5'd16, 5'd1, 5'd2),        // unmatched funct7
            enc_i(OPC_I, F3_BAD, 5'd17, 5'd1, 12'h123),
            enc_s(F3_BAD, 5'd0, 5'd1, 12'h004),
            {25'h0, OPC_END},
            32'hFFFF_FFFF
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Bursts of transactions separated by short gaps, now and then a long burst.
        total = directed_words.size() + RANDOM_ITEMS;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0) burst = 80;
            for (int k = 0; k < burst && sent < total; k++) begin
                if (directed_words.size() != 0) word = directed_words.pop_front();
                else word = random_instruction();
                send_instruction(word);
                sent++;
            end
            idle_sender($urandom_range(1, 6));
        end

        while (step_board.pending_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (step_board.failures == 0 && step_board.pending_steps.size() == 0) begin
            $display("[rv32i_subset_core_step] OK");
        end else begin
            $display("%0d failures, %0d results missing", step_board.failures,
                     step_board.pending_steps.size());
            $display("[rv32i_subset_core_step] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rvs_pkg.sv
hw/rtl/rvs_regfile.sv
hw/rtl/rvs_dmem.sv
hw/rtl/rvs_exec.sv
hw/rtl/rv32i_subset_core_step.sv
tb/tb_rv32i_subset_core_step.sv
